// ===== hw/rtl/sgr_attribute_interpreter_top_defines.svh =====
// assertion macros for the sgr attribute interpreter
`ifndef SGR_ATTRIBUTE_INTERPRETER_TOP_DEFINES_SVH
`define SGR_ATTRIBUTE_INTERPRETER_TOP_DEFINES_SVH

// same-cycle implication, checked on every clk edge outside reset
`define SGR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgr interpreter assertion failed");

// next-cycle implication, checked on every clk edge outside reset
`define SGR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgr interpreter assertion failed");

`endif

// ===== hw/rtl/sgr_pkg.sv =====
// types, codes and colour helpers for the sgr attribute interpreter
`default_nettype none

package sgr_pkg;

	// one sgr parameter item
	typedef struct packed {
		logic [15:0] param;
		logic [4:0]  params_left;
	} sgr_param_t;

	// attribute state after one item
	typedef struct packed {
		logic [3:0]  fg_index;
		logic [3:0]  bg_index;
		logic        fg_is_rgb;
		logic [23:0] fg_rgb;
		logic        bg_is_rgb;
		logic [23:0] bg_rgb;
		logic        bold_on;
		logic        underline_on;
		logic        strike_on;
		logic        reverse_on;
		logic        conceal_on;
	} sgr_attr_t;

	// progress through an extended colour form
	typedef enum logic [2:0] {
		PhIdle = 3'd0,
		PhSel  = 3'd1,
		PhR    = 3'd2,
		PhG    = 3'd3,
		PhB    = 3'd4,
		PhIdx  = 3'd5
	} sgr_phase_t;

	localparam logic [3:0] DefaultFg = 4'd7;
	localparam logic [3:0] DefaultBg = 4'd0;

	// plain codes
	localparam logic [15:0] SgrReset       = 16'd0;
	localparam logic [15:0] SgrBold        = 16'd1;
	localparam logic [15:0] SgrUnderline   = 16'd4;
	localparam logic [15:0] SgrBlink       = 16'd5;
	localparam logic [15:0] SgrReverse     = 16'd7;
	localparam logic [15:0] SgrConceal     = 16'd8;
	localparam logic [15:0] SgrStrike      = 16'd9;
	localparam logic [15:0] SgrBoldOffA    = 16'd21;
	localparam logic [15:0] SgrBoldOffB    = 16'd22;
	localparam logic [15:0] SgrUnderOff    = 16'd24;
	localparam logic [15:0] SgrBlinkOff    = 16'd25;
	localparam logic [15:0] SgrReverseOff  = 16'd27;
	localparam logic [15:0] SgrConcealOff  = 16'd28;
	localparam logic [15:0] SgrStrikeOff   = 16'd29;
	localparam logic [15:0] SgrFgLo        = 16'd30;
	localparam logic [15:0] SgrFgHi        = 16'd37;
	localparam logic [15:0] SgrFgExt       = 16'd38;
	localparam logic [15:0] SgrFgDefault   = 16'd39;
	localparam logic [15:0] SgrBgLo        = 16'd40;
	localparam logic [15:0] SgrBgHi        = 16'd47;
	localparam logic [15:0] SgrBgExt       = 16'd48;
	localparam logic [15:0] SgrBgDefault   = 16'd49;
	localparam logic [15:0] SgrFgBrightLo  = 16'd90;
	localparam logic [15:0] SgrFgBrightHi  = 16'd97;
	localparam logic [15:0] SgrBgBrightLo  = 16'd100;
	localparam logic [15:0] SgrBgBrightHi  = 16'd107;

	// extended form selectors
	localparam logic [15:0] SelRgb   = 16'd2;
	localparam logic [15:0] SelIndex = 16'd5;

	localparam logic [15:0] PaletteSize  = 16'd16;
	localparam logic [15:0] IndexLimit   = 16'd256;
	localparam logic [7:0]  GreyBase     = 8'd232;

	localparam sgr_attr_t AttrReset = '{
		fg_index:     DefaultFg,
		bg_index:     DefaultBg,
		fg_is_rgb:    1'b0,
		fg_rgb:       24'd0,
		bg_is_rgb:    1'b0,
		bg_rgb:       24'd0,
		bold_on:      1'b0,
		underline_on: 1'b0,
		strike_on:    1'b0,
		reverse_on:   1'b0,
		conceal_on:   1'b0
	};

	// intensity of one step of the 6x6x6 cube
	function automatic logic [7:0] cube_level(input logic [2:0] step);
		logic [7:0] lvl;
		case (step)
			3'd0:    lvl = 8'd0;
			3'd1:    lvl = 8'd95;
			3'd2:    lvl = 8'd135;
			3'd3:    lvl = 8'd175;
			3'd4:    lvl = 8'd215;
			default: lvl = 8'd255;
		endcase
		return lvl;
	endfunction

	// xterm colour for indexes 16 to 255, r in the low byte
	function automatic logic [23:0] xterm_rgb(input logic [7:0] n);
		logic [7:0] k;
		logic [7:0] rem;
		logic [7:0] grey;
		logic [2:0] r_step;
		logic [2:0] g_step;
		logic [2:0] b_step;
		logic [23:0] rgb;
		k      = n - 8'd16;
		r_step = 3'd0;
		for (int i = 1; i < 6; i++) begin
			if (k >= 8'(36 * i))
				r_step = 3'(i);
		end
		rem    = k - 8'(r_step) * 8'd36;
		g_step = 3'd0;
		for (int i = 1; i < 6; i++) begin
			if (rem >= 8'(6 * i))
				g_step = 3'(i);
		end
		b_step = 3'(rem - 8'(g_step) * 8'd6);
		grey   = 8'd8 + (n - GreyBase) * 8'd10;
		if (n >= GreyBase)
			rgb = {grey, grey, grey};
		else
			rgb = {cube_level(b_step), cube_level(g_step), cube_level(r_step)};
		return rgb;
	endfunction

	function automatic logic [7:0] clamp_byte(input logic [15:0] v);
		return (v > 16'd255) ? 8'd255 : v[7:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sgr_attribute_interpreter_top.sv =====
// sgr attribute interpreter: parameter items in, attribute state out
//
//  channel  | signals                                 | carries
//  ---------+-----------------------------------------+----------------------------------
//  param    | param_valid, param_ready, param_item    | one sgr parameter and count left
//  attr     | attr_valid, attr_ready, attr            | attribute state after that item
//
// one item per cycle sustained while results are taken; the attribute and extended-form
// registers are updated by the decode between the input register and the result register
// each item passes the input register, then the result register
// arst_n low returns foreground 7, background 0, rgb off, flags clear, no extended form
// a stalled result holds the state; the input register still takes one more item
`default_nettype none
`include "sgr_attribute_interpreter_top_defines.svh"

module sgr_attribute_interpreter_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               param_valid,
	output      logic               param_ready,
	input  wire sgr_pkg::sgr_param_t param_item,
	output      logic               attr_valid,
	input  wire logic               attr_ready,
	output      sgr_pkg::sgr_attr_t attr
);
	import sgr_pkg::*;

	// input stage
	sgr_param_t item_s1;
	logic       valid_s1;

	// attribute state doubles as the result register
	sgr_attr_t  attr_q;
	logic       attr_valid_q;

	// extended colour form tracking
	sgr_phase_t phase_q;
	logic       target_back_q;
	logic [15:0] partial_q;

	logic       advance;

	sgr_attr_t  plain_attr;
	logic       plain_ext;
	logic       plain_back;

	sgr_attr_t  attr_n;
	sgr_phase_t phase_n;
	logic       target_back_n;
	logic [15:0] partial_n;
	logic       use_plain;
	logic [7:0] comp;
	logic [15:0] p;
	logic [4:0] left;

	assign p    = item_s1.param;
	assign left = item_s1.params_left;

	// the item in the input register moves on whenever the result register is free
	assign advance     = valid_s1 && (!attr_valid_q || attr_ready);
	assign param_ready = !valid_s1 || advance;
	assign attr_valid  = attr_valid_q;
	assign attr        = attr_q;
	assign comp        = clamp_byte(p);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (param_ready) begin
			valid_s1 <= param_valid;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (param_valid && param_ready) begin
			item_s1 <= param_item;
		end
	end

	// decode of a plain code against the current state
	always_comb begin
		plain_attr = attr_q;
		plain_ext  = 1'b0;
		plain_back = target_back_q;
		case (p) inside
			[SgrFgLo:SgrFgHi]: begin
				plain_attr.fg_index  = 4'(p - SgrFgLo);
				plain_attr.fg_is_rgb = 1'b0;
			end
			[SgrFgBrightLo:SgrFgBrightHi]: begin
				plain_attr.fg_index  = 4'(p - SgrFgBrightLo + 16'd8);
				plain_attr.fg_is_rgb = 1'b0;
			end
			[SgrBgLo:SgrBgHi]: begin
				plain_attr.bg_index  = 4'(p - SgrBgLo);
				plain_attr.bg_is_rgb = 1'b0;
			end
			[SgrBgBrightLo:SgrBgBrightHi]: begin
				plain_attr.bg_index  = 4'(p - SgrBgBrightLo + 16'd8);
				plain_attr.bg_is_rgb = 1'b0;
			end
			SgrFgExt, SgrBgExt: begin
				// needs a selector and at least one value behind it
				if (left >= 5'd2) begin
					plain_ext  = 1'b1;
					plain_back = (p == SgrBgExt);
				end
			end
			SgrReset: begin
				plain_attr = AttrReset;
			end
			SgrFgDefault: begin
				plain_attr.reverse_on = 1'b0;
				plain_attr.fg_index   = DefaultFg;
				plain_attr.fg_is_rgb  = 1'b0;
				plain_attr.fg_rgb     = 24'd0;
			end
			SgrBgDefault: begin
				plain_attr.reverse_on = 1'b0;
				plain_attr.bg_index   = DefaultBg;
				plain_attr.bg_is_rgb  = 1'b0;
				plain_attr.bg_rgb     = 24'd0;
			end
			SgrBold:                    plain_attr.bold_on      = 1'b1;
			SgrUnderline, SgrBlink:     plain_attr.underline_on = 1'b1;
			SgrReverse:                 plain_attr.reverse_on   = 1'b1;
			SgrConceal:                 plain_attr.conceal_on   = 1'b1;
			SgrStrike:                  plain_attr.strike_on    = 1'b1;
			SgrBoldOffA, SgrBoldOffB:   plain_attr.bold_on      = 1'b0;
			SgrUnderOff, SgrBlinkOff:   plain_attr.underline_on = 1'b0;
			SgrReverseOff:              plain_attr.reverse_on   = 1'b0;
			SgrConcealOff:              plain_attr.conceal_on   = 1'b0;
			SgrStrikeOff:               plain_attr.strike_on    = 1'b0;
			default: ;
		endcase
	end

	// next state: extended form steps, else the plain decode
	always_comb begin
		attr_n        = attr_q;
		phase_n       = PhIdle;
		target_back_n = target_back_q;
		partial_n     = partial_q;
		use_plain     = 1'b0;
		unique case (phase_q)
			PhSel: begin
				if (p == SelRgb && left >= 5'd3)
					phase_n = PhR;
				else if (p == SelIndex && left >= 5'd1)
					phase_n = PhIdx;
				else
					use_plain = 1'b1;   // selector falls back to a plain code
			end
			PhR: begin
				partial_n = {8'd0, comp};
				phase_n   = PhG;
			end
			PhG: begin
				partial_n = {comp, partial_q[7:0]};
				phase_n   = PhB;
			end
			PhB: begin
				if (target_back_q) begin
					attr_n.bg_is_rgb = 1'b1;
					attr_n.bg_rgb    = {comp, partial_q};
				end else begin
					attr_n.fg_is_rgb = 1'b1;
					attr_n.fg_rgb    = {comp, partial_q};
				end
			end
			PhIdx: begin
				if (p < PaletteSize) begin
					if (target_back_q) begin
						attr_n.bg_index  = p[3:0];
						attr_n.bg_is_rgb = 1'b0;
					end else begin
						attr_n.fg_index  = p[3:0];
						attr_n.fg_is_rgb = 1'b0;
					end
				end else if (p < IndexLimit) begin
					if (target_back_q) begin
						attr_n.bg_is_rgb = 1'b1;
						attr_n.bg_rgb    = xterm_rgb(p[7:0]);
					end else begin
						attr_n.fg_is_rgb = 1'b1;
						attr_n.fg_rgb    = xterm_rgb(p[7:0]);
					end
				end
				// out-of-range index is swallowed
			end
			default: begin
				use_plain = 1'b1;
			end
		endcase
		if (use_plain) begin
			attr_n        = plain_attr;
			phase_n       = plain_ext ? PhSel : PhIdle;
			target_back_n = plain_back;
		end
		// the last parameter of a sequence always closes any extended form
		if (left == 5'd0)
			phase_n = PhIdle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q        <= AttrReset;
			phase_q       <= PhIdle;
			target_back_q <= 1'b0;
			partial_q     <= 16'd0;
		end else if (advance) begin
			attr_q        <= attr_n;
			phase_q       <= phase_n;
			target_back_q <= target_back_n;
			partial_q     <= partial_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_valid_q <= 1'b0;
		end else if (advance) begin
			attr_valid_q <= 1'b1;
		end else if (attr_ready) begin
			attr_valid_q <= 1'b0;
		end
	end

	// a last parameter leaves no extended form open
	`SGR_ASSERT_NEXT(a_last_closes_ext, advance && left == 5'd0, phase_q == PhIdle)
	// state only moves when an item is taken into the result register
	`SGR_ASSERT_NEXT(a_state_holds, !advance, $stable(attr_q) && $stable(phase_q))
	// the red component is always followed by green unless the sequence ends
	`SGR_ASSERT_NEXT(a_r_then_g, advance && phase_q == PhR && left != 5'd0, phase_q == PhG)
	// an empty input register always takes an item
	`SGR_ASSERT_SAME(a_ready_when_empty, !valid_s1, param_ready)
	// a waiting result stays offered and unchanged
	`SGR_ASSERT_NEXT(a_attr_held, attr_valid_q && !attr_ready, attr_valid_q && $stable(attr_q))

endmodule

`default_nettype wire

// ===== test/tb_sgr_attribute_interpreter_top.sv =====
// self-checking testbench for the sgr attribute interpreter with a predicting scoreboard
`default_nettype none

module tb_sgr_attribute_interpreter_top;
	import sgr_pkg::*;

	localparam int unsigned ItemTarget  = 950;
	// the sink pauses for a long stretch once this many cycles have gone by
	localparam int unsigned HoldOffAt   = 2000;
	localparam int unsigned HoldOffLen  = 400;
	localparam int unsigned DrainCycles = 8;

	logic       clk;
	logic       arst_n;
	logic       param_valid;
	logic       param_ready;
	sgr_param_t param_item;
	logic       attr_valid;
	logic       attr_ready;
	sgr_attr_t  attr;

	// tracks the attribute state and the extended colour form item by item
	class sgr_attr_predictor;
		sgr_attr_t   state;
		sgr_phase_t  phase;
		bit          to_back;
		logic [15:0] partial_rg;
		sgr_attr_t   expected_attrs[$];
		int unsigned failures;

		function new();
			state      = AttrReset;
			phase      = PhIdle;
			to_back    = 1'b0;
			partial_rg = '0;
			failures   = 0;
		endfunction

		function logic [7:0] clamp_level(logic [15:0] v);
			return (v > 16'd255) ? 8'hff : v[7:0];
		endfunction

		// cube steps run 0, 95, 135, 175, 215, 255
		function logic [7:0] cube_step(int unsigned s);
			return (s == 0) ? 8'd0 : 8'(55 + 40 * s);
		endfunction

		function logic [23:0] xterm_colour(int unsigned n);
			int unsigned k;
			logic [7:0]  r;
			logic [7:0]  g;
			logic [7:0]  b;
			if (n >= 232) begin
				r = 8'(8 + 10 * (n - 232));
				g = r;
				b = r;
			end else begin
				k = n - 16;
				r = cube_step((k / 36) % 6);
				g = cube_step((k / 6) % 6);
				b = cube_step(k % 6);
			end
			return {b, g, r};
		endfunction

		function void set_palette(logic [3:0] idx);
			if (to_back) begin
				state.bg_index  = idx;
				state.bg_is_rgb = 1'b0;
			end else begin
				state.fg_index  = idx;
				state.fg_is_rgb = 1'b0;
			end
		endfunction

		function void set_rgb(logic [23:0] rgb);
			if (to_back) begin
				state.bg_is_rgb = 1'b1;
				state.bg_rgb    = rgb;
			end else begin
				state.fg_is_rgb = 1'b1;
				state.fg_rgb    = rgb;
			end
		endfunction

		function void plain_code(logic [15:0] code, int unsigned left);
			if (code >= SgrFgLo && code <= SgrFgHi) begin
				state.fg_index  = 4'(code - SgrFgLo);
				state.fg_is_rgb = 1'b0;
			end else if (code >= SgrFgBrightLo && code <= SgrFgBrightHi) begin
				state.fg_index  = 4'(code - SgrFgBrightLo) | 4'd8;
				state.fg_is_rgb = 1'b0;
			end else if (code >= SgrBgLo && code <= SgrBgHi) begin
				state.bg_index  = 4'(code - SgrBgLo);
				state.bg_is_rgb = 1'b0;
			end else if (code >= SgrBgBrightLo && code <= SgrBgBrightHi) begin
				state.bg_index  = 4'(code - SgrBgBrightLo) | 4'd8;
				state.bg_is_rgb = 1'b0;
			end else if (code == SgrFgExt || code == SgrBgExt) begin
				// an extended form needs at least a selector and one value after it
				if (left >= 2) begin
					phase   = PhSel;
					to_back = (code == SgrBgExt);
				end
			end else begin
				case (code)
					SgrReset: state = AttrReset;
					SgrFgDefault: begin
						state.reverse_on = 1'b0;
						state.fg_index   = DefaultFg;
						state.fg_is_rgb  = 1'b0;
						state.fg_rgb     = '0;
					end
					SgrBgDefault: begin
						state.reverse_on = 1'b0;
						state.bg_index   = DefaultBg;
						state.bg_is_rgb  = 1'b0;
						state.bg_rgb     = '0;
					end
					SgrBold:       state.bold_on      = 1'b1;
					SgrUnderline:  state.underline_on = 1'b1;
					SgrBlink:      state.underline_on = 1'b1;
					SgrReverse:    state.reverse_on   = 1'b1;
					SgrConceal:    state.conceal_on   = 1'b1;
					SgrStrike:     state.strike_on    = 1'b1;
					SgrBoldOffA:   state.bold_on      = 1'b0;
					SgrBoldOffB:   state.bold_on      = 1'b0;
					SgrUnderOff:   state.underline_on = 1'b0;
					SgrBlinkOff:   state.underline_on = 1'b0;
					SgrReverseOff: state.reverse_on   = 1'b0;
					SgrConcealOff: state.conceal_on   = 1'b0;
					SgrStrikeOff:  state.strike_on    = 1'b0;
					default: ;
				endcase
			end
		endfunction

		// one accepted parameter item gives one expected attribute item
		function void note_param(sgr_param_t item);
			logic [15:0] p;
			int unsigned left;
			p    = item.param;
			left = item.params_left;
			case (phase)
				PhSel: begin
					if (p == SelRgb && left >= 3)
						phase = PhR;
					else if (p == SelIndex && left >= 1)
						phase = PhIdx;
					else begin
						// selector not usable: fall back to a plain code
						phase = PhIdle;
						plain_code(p, left);
					end
				end
				PhR: begin
					partial_rg = {8'h00, clamp_level(p)};
					phase      = PhG;
				end
				PhG: begin
					partial_rg[15:8] = clamp_level(p);
					phase            = PhB;
				end
				PhB: begin
					set_rgb({clamp_level(p), partial_rg});
					phase = PhIdle;
				end
				PhIdx: begin
					if (p < PaletteSize)
						set_palette(p[3:0]);
					else if (p < IndexLimit)
						set_rgb(xterm_colour(p));
					phase = PhIdle;
				end
				default: begin
					phase = PhIdle;
					plain_code(p, left);
				end
			endcase
			// the last parameter always ends any extended form
			if (left == 0)
				phase = PhIdle;
			expected_attrs = {expected_attrs, state};
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_attr(sgr_attr_t got);
			sgr_attr_t want;
			if (expected_attrs.size() == 0) begin
				$error("attr item arrived with no expectation waiting");
				failures++;
				return;
			end
			want = expected_attrs.pop_front();
			compare_field("fg_index", want.fg_index, got.fg_index);
			compare_field("bg_index", want.bg_index, got.bg_index);
			compare_field("fg_is_rgb", want.fg_is_rgb, got.fg_is_rgb);
			compare_field("fg_rgb", want.fg_rgb, got.fg_rgb);
			compare_field("bg_is_rgb", want.bg_is_rgb, got.bg_is_rgb);
			compare_field("bg_rgb", want.bg_rgb, got.bg_rgb);
			compare_field("bold_on", want.bold_on, got.bold_on);
			compare_field("underline_on", want.underline_on, got.underline_on);
			compare_field("strike_on", want.strike_on, got.strike_on);
			compare_field("reverse_on", want.reverse_on, got.reverse_on);
			compare_field("conceal_on", want.conceal_on, got.conceal_on);
		endfunction

		function int unsigned pending();
			return expected_attrs.size();
		endfunction
	endclass

	sgr_attr_predictor attr_predictor;
	logic [15:0]       code_list[$];
	int unsigned       items_sent;

	sgr_attribute_interpreter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.param_valid(param_valid),
		.param_ready(param_ready),
		.param_item (param_item),
		.attr_valid (attr_valid),
		.attr_ready (attr_ready),
		.attr       (attr)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// pause lengths: mostly short, now and then long
	function automatic int unsigned idle_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_plain();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1: begin
				case ($urandom_range(0, 12))
					0:       return SgrBold;
					1:       return SgrUnderline;
					2:       return SgrBlink;
					3:       return SgrReverse;
					4:       return SgrConceal;
					5:       return SgrStrike;
					6:       return SgrBoldOffA;
					7:       return SgrBoldOffB;
					8:       return SgrUnderOff;
					9:       return SgrBlinkOff;
					10:      return SgrReverseOff;
					11:      return SgrConcealOff;
					default: return SgrStrikeOff;
				endcase
			end
			2: return SgrFgLo + 16'($urandom_range(0, 7));
			3: return SgrFgBrightLo + 16'($urandom_range(0, 7));
			4: return SgrBgLo + 16'($urandom_range(0, 7));
			5: return SgrBgBrightLo + 16'($urandom_range(0, 7));
			6: return SgrReset;
			7: return ($urandom_range(0, 1) != 0) ? SgrFgDefault : SgrBgDefault;
			default: return 16'($urandom_range(0, 110));
		endcase
	endfunction

	function automatic logic [15:0] pick_component();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 16'($urandom_range(0, 255));
		else if (r < 75)
			return 16'($urandom_range(256, 65535));
		else if (r < 85)
			return 16'hffff;
		return ($urandom_range(0, 1) != 0) ? 16'd255 : 16'd0;
	endfunction

	function automatic logic [15:0] pick_index();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return 16'($urandom_range(0, 15));
		else if (r < 85)
			return 16'($urandom_range(16, 255));
		return 16'($urandom_range(256, 65535));
	endfunction

	// appends one parameter to the list being built
	function automatic void add_code(logic [15:0] value);
		code_list = {code_list, value};
	endfunction

	// a parameter list of plain codes and extended forms, sometimes cut short at the end
	task automatic build_sequence();
		int unsigned parts;
		int unsigned kind;
		int unsigned drop;
		logic [15:0] ext;
		code_list.delete();
		parts = ($urandom_range(0, 99) < 10) ? $urandom_range(7, 12) : $urandom_range(1, 4);
		repeat (parts) begin
			kind = $urandom_range(0, 99);
			ext  = ($urandom_range(0, 1) != 0) ? SgrBgExt : SgrFgExt;
			if (kind < 45) begin
				add_code(pick_plain());
			end else if (kind < 65) begin
				add_code(ext);
				add_code(SelRgb);
				add_code(pick_component());
				add_code(pick_component());
				add_code(pick_component());
			end else if (kind < 85) begin
				add_code(ext);
				add_code(SelIndex);
				add_code(pick_index());
			end else begin
				// selector that may not be usable
				add_code(ext);
				add_code(16'($urandom_range(0, 9)));
			end
		end
		if (code_list.size() > 1 && $urandom_range(0, 99) < 15) begin
			drop = $urandom_range(1, 3);
			while (drop > 0 && code_list.size() > 1) begin
				void'(code_list.pop_back());
				drop--;
			end
		end
		while (code_list.size() > 32)
			void'(code_list.pop_back());
	endtask

	task automatic send_param(logic [15:0] value, logic [4:0] left);
		int unsigned gap;
		if ((items_sent / 128) % 4 == 2)
			gap = 0;
		else
			gap = ($urandom_range(0, 99) < 60) ? 0 : idle_length();
		if (gap > 0) begin
			param_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		param_item  <= '{param: value, params_left: left};
		param_valid <= 1'b1;
		do
			@(posedge clk);
		while (!param_ready);
		attr_predictor.note_param(param_item);
		items_sent++;
	endtask

	task automatic send_sequence();
		for (int i = 0; i < code_list.size(); i++)
			send_param(code_list[i], 5'(code_list.size() - 1 - i));
	endtask

	// result side: random back-pressure plus one long hold-off
	initial begin : result_sink
		int unsigned hold;
		int unsigned cycle;
		bit          held_off;
		attr_ready <= 1'b0;
		hold     = 0;
		cycle    = 0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold > 0) begin
				hold--;
				attr_ready <= 1'b0;
			end else if (!held_off && cycle >= HoldOffAt) begin
				held_off = 1'b1;
				hold     = HoldOffLen - 1;
				attr_ready <= 1'b0;
			end else if ((cycle / 512) % 4 == 1 || $urandom_range(0, 99) < 70) begin
				attr_ready <= 1'b1;
			end else begin
				hold = idle_length() - 1;
				attr_ready <= 1'b0;
			end
			@(posedge clk);
			cycle++;
			if (attr_valid && attr_ready)
				attr_predictor.check_attr(attr);
		end
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		attr_predictor = new();
		items_sent     = 0;
		param_valid <= 1'b0;
		param_item  <= '0;
		arst_n      <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset, every flag, an unknown code at the top of the range
		code_list = '{SgrReset};
		send_sequence();
		code_list = '{SgrBold, SgrBlink, SgrReverse, SgrConceal, SgrStrike, 16'hffff};
		send_sequence();
		// background form whose selector is a plain colour code
		code_list = '{SgrBgExt, SgrFgBrightLo, SgrBgBrightHi};
		send_sequence();
		// rgb with clamped components
		code_list = '{SgrFgExt, SelRgb, 16'hffff, 16'd0, 16'd300};
		send_sequence();
		// cube corner, grey ramp top, out-of-range index
		code_list = '{SgrBgExt, SelIndex, 16'd231};
		send_sequence();
		code_list = '{SgrFgExt, SelIndex, 16'd255, SgrBgExt, SelIndex, 16'hffff};
		send_sequence();
		// rgb form cut short by the end of the list
		code_list = '{SgrFgExt, SelRgb, 16'd10};
		send_sequence();

		while (items_sent < ItemTarget) begin
			if ($urandom_range(0, 99) < 85) begin
				build_sequence();
				send_sequence();
			end else if ($urandom_range(0, 1) != 0) begin
				send_param(16'($urandom_range(0, 110)), 5'($urandom_range(0, 31)));
			end else begin
				send_param(16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
			end
		end
		param_valid <= 1'b0;

		while (attr_predictor.pending() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (attr_predictor.failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sgr_attribute_interpreter_top.f =====
+incdir+hw/rtl
hw/rtl/sgr_pkg.sv
hw/rtl/sgr_attribute_interpreter_top.sv
test/tb_sgr_attribute_interpreter_top.sv
